@@ src/pcs_pkg.sv @@
// Shared types and constants for the PCI type-0 configuration header block.
`default_nettype none
package pcs_pkg;

   // Sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BARS
   } pcs_state_type;

   // Request kinds carried on req_tuser
   localparam logic [1:0] CMD_READ   = 2'd0;
   localparam logic [1:0] CMD_WRITE  = 2'd1;
   localparam logic [1:0] CMD_DECODE = 2'd2;
   localparam logic [1:0] CMD_IRQ    = 2'd3;

   // Register indexes of the write port
   localparam logic [2:0] CSR_ID      = 3'd0;
   localparam logic [2:0] CSR_CLASS   = 3'd1;
   localparam logic [2:0] CSR_SUBSYS  = 3'd2;
   localparam logic [2:0] CSR_MISC    = 3'd3;
   localparam logic [2:0] CSR_BAR_EN  = 3'd4;
   localparam logic [2:0] CSR_BAR_MEM = 3'd5;
   localparam logic [2:0] CSR_BAR_SZ  = 3'd6;
   localparam logic [2:0] CSR_BAR_TYP = 3'd7;

   localparam int LANES       = 4;
   localparam int CSR_DATA_W  = 36;
   localparam int REQ_DATA_W  = 72;
   localparam int RSP_DATA_W  = 80;
   localparam int HEADER_BYTES = 64;

   // Header offsets with writable bits, and the read-only interrupt pin
   localparam logic [5:0] OFF_CMD_LO  = 6'h04;
   localparam logic [5:0] OFF_CMD_HI  = 6'h05;
   localparam logic [5:0] OFF_CLS     = 6'h0c;
   localparam logic [5:0] OFF_INTLINE = 6'h3c;
   localparam logic [5:0] OFF_INTPIN  = 6'h3d;
   localparam logic [5:0] OFF_BAR0    = 6'h10;

endpackage
`default_nettype wire

@@ src/pcs_ext_store.sv @@
// Byte-lane memories for the configuration space above the header, with clearing pass.
`default_nettype none
module pcs_ext_store #(
   parameter int ROWS = 48,
   parameter int RW   = 6
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          rd_en,
   input  wire logic [RW-1:0] rd_row  [pcs_pkg::LANES],
   input  wire logic          wr_en   [pcs_pkg::LANES],
   input  wire logic [RW-1:0] wr_row  [pcs_pkg::LANES],
   input  wire logic [7:0]    wr_data [pcs_pkg::LANES],
   output logic      [7:0]    rd_data [pcs_pkg::LANES],
   output logic               busy
);
   import pcs_pkg::*;

   logic [RW:0] clr_ff;
   logic [RW:0] clr_in;

   // Sweep every row to zero after reset
   assign busy = (clr_ff < (RW+1)'(ROWS));

   always_comb begin
      clr_in = clr_ff;
      if (busy) begin
         clr_in = clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
   end

   for (genvar j = 0; j < LANES; j++) begin : g_lane
      logic [7:0] mem [ROWS];

      // Write port: clearing pass has priority
      always_ff @(posedge clock) begin
         if (busy) begin
            mem[clr_ff[RW-1:0]] <= 8'h00;
         end else if (wr_en[j]) begin
            mem[wr_row[j]] <= wr_data[j];
         end
      end

      // Registered read port
      always_ff @(posedge clock) begin
         if (rd_en) begin
            rd_data[j] <= mem[rd_row[j]];
         end
      end
   end

endmodule
`default_nettype wire

@@ src/pci_config_space_bar_decode_core.sv @@
// PCI type-0 configuration header with BAR decode: top level.
// An accepted beat is registered and moves the sequencer to ST_EXEC; an in-range
// config write then goes on to ST_BARS, which recomputes the BAR decodes. The
// result register is loaded from ST_BARS for such a write and from ST_EXEC else,
// while the output is not stalled. Only ST_IDLE takes a new beat. Reset: synchronous;
// a clearing pass zeroes the extended store, during which no request beat is taken.
`default_nettype none
module pci_config_space_bar_decode_core #(
   parameter int NUM_BARS     = 6,
   parameter int CONFIG_BYTES = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic [2:0]                      csr_index,
   input  wire logic [pcs_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // addr[31:0], wdata[63:32], nbytes[66:64], space_is_mem[67], level[68], zero pad
   input  wire logic [pcs_pkg::REQ_DATA_W-1:0]  req_tdata,
   // cmd[1:0]
   input  wire logic [1:0]                      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // rdata[31:0], addr_error[32], hit[33], bar_index[36:34], bar_offset[68:37],
   // map_changed[74:69], irq_notify[75], intx_disabled[76], zero pad
   output logic [pcs_pkg::RSP_DATA_W-1:0]       rsp_tdata
);
   import pcs_pkg::*;

   localparam int AW       = $clog2(CONFIG_BYTES);
   localparam int ROWS_RAW = (CONFIG_BYTES - HEADER_BYTES) / 4;
   localparam int ROWS     = (ROWS_RAW > 0) ? ROWS_RAW : 1;
   localparam int RW       = (ROWS > 1) ? $clog2(ROWS) : 1;

   // Configuration registers
   logic [31:0] id_ff, subsys_ff;
   logic [23:0] class_ff;
   logic [18:0] misc_ff;
   logic [5:0]  bar_en_ff, bar_mem_ff;
   logic [35:0] bar_sz_ff;
   logic [17:0] bar_typ_ff;

   // Header store and decode state
   logic [2:0]  cmd_lo_ff, cmd_lo_in;
   logic        cmd_b10_ff, cmd_b10_in;
   logic [7:0]  cls_ff, cls_in;
   logic [7:0]  intl_ff, intl_in;
   logic [31:0] bar_ff   [NUM_BARS];
   logic [31:0] bar_in   [NUM_BARS];
   logic [31:0] base_ff  [NUM_BARS];
   logic [31:0] base_in  [NUM_BARS];
   logic        mapped_ff [NUM_BARS];
   logic        mapped_in [NUM_BARS];
   logic        irq_ff, irq_in;

   // Request registers
   logic [1:0]  cmd_ff;
   logic [31:0] addr_ff;
   logic [31:0] wdata_ff;
   logic [2:0]  nb_ff;
   logic        space_ff;
   logic        lvl_ff;

   pcs_state_type state_ff, state_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   logic        accept, out_free, busy;
   logic [RW-1:0] rd_row  [LANES];
   logic          wr_en   [LANES];
   logic [RW-1:0] wr_row  [LANES];
   logic [7:0]    wr_data [LANES];
   logic [7:0]    rd_data [LANES];

   // Per-BAR write mask from its size
   function automatic logic [31:0] bar_mask(input int i);
      logic [5:0] s;
      s = bar_sz_ff[6*i +: 6];
      bar_mask = (s >= 6'd32) ? 32'h0 : (32'hffff_ffff << s[4:0]);
   endfunction

   // Header write mask
   function automatic logic [7:0] hdr_mask(input logic [5:0] off);
      logic [7:0] m;
      logic [31:0] bmw;
      m = 8'h00;
      if (off == OFF_CMD_LO) m = 8'h07;
      else if (off == OFF_CMD_HI) m = 8'h04;
      else if (off == OFF_CLS || off == OFF_INTLINE) m = 8'hff;
      else begin
         for (int i = 0; i < NUM_BARS; i++) begin
            if (off[5:2] == 4'(4 + i) && bar_en_ff[i]) begin
               bmw = bar_mask(i);
               m = bmw[8*off[1:0] +: 8];
            end
         end
      end
      return m;
   endfunction

   // Header bits fixed by the registers
   function automatic logic [7:0] hdr_fixed(input logic [5:0] off);
      logic [7:0] f;
      f = 8'h00;
      if (off < 6'd4) f = id_ff[8*off[1:0] +: 8];
      else if (off >= 6'd8 && off < 6'd11) f = class_ff[8*off[1:0] +: 8];
      else if (off == 6'h0e) f = misc_ff[7:0];
      else if (off == 6'h0f) f = misc_ff[15:8];
      else if (off >= 6'h2c && off < 6'h30) f = subsys_ff[8*off[1:0] +: 8];
      else if (off == OFF_INTPIN) f = (misc_ff[18:16] <= 3'd4) ? {5'd0, misc_ff[18:16]} : 8'h00;
      else begin
         for (int i = 0; i < NUM_BARS; i++) begin
            if (off[5:2] == 4'(4 + i) && off[1:0] == 2'd0 && bar_en_ff[i]) begin
               f = bar_mem_ff[i] ? {4'd0, bar_typ_ff[3*i +: 3], 1'b0} : 8'h01;
            end
         end
      end
      return f;
   endfunction

   // Stored header byte
   function automatic logic [7:0] hdr_store(input logic [5:0] off);
      logic [7:0] v;
      v = 8'h00;
      if (off == OFF_CMD_LO) v = {5'd0, cmd_lo_ff};
      else if (off == OFF_CMD_HI) v = {5'd0, cmd_b10_ff, 2'd0};
      else if (off == OFF_CLS) v = cls_ff;
      else if (off == OFF_INTLINE) v = intl_ff;
      else begin
         for (int i = 0; i < NUM_BARS; i++) begin
            if (off[5:2] == 4'(4 + i)) v = bar_ff[i][8*off[1:0] +: 8];
         end
      end
      return v;
   endfunction

   // Byte offset of lane j for an access at addr
   function automatic logic [AW:0] lane_off(input logic [31:0] a, input int j);
      logic [1:0] k;
      k = 2'(j) - a[1:0];
      return {1'b0, a[AW-1:0]} + (AW+1)'(k);
   endfunction

   function automatic logic [RW-1:0] lane_row(input logic [AW:0] off);
      logic [AW-2:0] r;
      r = off[AW:2] - (AW-1)'(HEADER_BYTES / 4);
      return r[RW-1:0];
   endfunction

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE) && !busy;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Extended configuration store
   pcs_ext_store #(.ROWS(ROWS), .RW(RW)) u_store (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (accept),
      .rd_row  (rd_row),
      .wr_en   (wr_en),
      .wr_row  (wr_row),
      .wr_data (wr_data),
      .rd_data (rd_data),
      .busy    (busy)
   );

   // Issue lane reads from the incoming address
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         rd_row[j] = lane_row(lane_off(req_tdata[31:0], j));
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: begin
            if (cmd_ff == CMD_WRITE && addr_ff < 32'(CONFIG_BYTES)) state_in = ST_BARS;
            else if (out_free) state_in = ST_IDLE;
         end
         ST_BARS: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath: execute, write back, recompute BARs, load result
   always_comb begin
      logic [2:0]  neff;
      logic        in_rng;
      logic [AW:0] off;
      logic [1:0]  k;
      logic        lv;
      logic [7:0]  m, b, wb;
      logic [31:0] rdata, offs, a, bm;
      logic        hit, mp;
      logic [2:0]  bidx;
      logic [31:0] boff;
      logic [5:0]  chg;
      logic        irqn;

      cmd_lo_in  = cmd_lo_ff;
      cmd_b10_in = cmd_b10_ff;
      cls_in     = cls_ff;
      intl_in    = intl_ff;
      irq_in     = irq_ff;
      for (int i = 0; i < NUM_BARS; i++) begin
         bar_in[i]    = bar_ff[i];
         base_in[i]   = base_ff[i];
         mapped_in[i] = mapped_ff[i];
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      neff   = (nb_ff > 3'd4) ? 3'd4 : nb_ff;
      in_rng = addr_ff < 32'(CONFIG_BYTES);
      rdata  = 32'h0;
      hit    = 1'b0;
      bidx   = 3'd0;
      boff   = 32'h0;
      chg    = 6'd0;
      irqn   = 1'b0;

      // Per-lane read data and write enables
      for (int j = 0; j < LANES; j++) begin
         off = lane_off(addr_ff, j);
         k   = 2'(j) - addr_ff[1:0];
         lv  = in_rng && ({1'b0, k} < neff) && (off < (AW+1)'(CONFIG_BYTES));
         wb  = wdata_ff[8*k +: 8];
         wr_row[j]  = lane_row(off);
         wr_data[j] = wb;
         wr_en[j]   = 1'b0;
         if (lv) begin
            if (off < (AW+1)'(HEADER_BYTES)) begin
               m = hdr_mask(off[5:0]);
               b = (hdr_store(off[5:0]) & m) | (hdr_fixed(off[5:0]) & ~m);
            end else begin
               b = rd_data[j];
            end
            rdata[8*k +: 8] = b;
            if (state_ff == ST_EXEC && cmd_ff == CMD_WRITE) begin
               if (off < (AW+1)'(HEADER_BYTES)) begin
                  m = hdr_mask(off[5:0]);
                  if (off[5:0] == OFF_CMD_LO) cmd_lo_in = wb[2:0];
                  else if (off[5:0] == OFF_CMD_HI) cmd_b10_in = wb[2];
                  else if (off[5:0] == OFF_CLS) cls_in = wb;
                  else if (off[5:0] == OFF_INTLINE) intl_in = wb;
                  for (int i = 0; i < NUM_BARS; i++) begin
                     if (off[5:2] == 4'(4 + i)) begin
                        bar_in[i][8*off[1:0] +: 8] =
                           (bar_ff[i][8*off[1:0] +: 8] & ~m) | (wb & m);
                     end
                  end
               end else begin
                  wr_en[j] = 1'b1;
               end
            end
         end
      end

      // Decode: first mapped BAR of the requested space
      for (int i = NUM_BARS - 1; i >= 0; i--) begin
         offs = addr_ff - base_ff[i];
         if (bar_en_ff[i] && (bar_mem_ff[i] == space_ff) && mapped_ff[i] &&
             base_ff[i] <= addr_ff &&
             (bar_sz_ff[6*i +: 6] >= 6'd32 || (offs >> bar_sz_ff[6*i +: 5]) == 32'h0)) begin
            hit  = 1'b1;
            bidx = 3'(i);
            boff = offs;
         end
      end

      // Recompute BAR mappings after a write
      for (int i = 0; i < NUM_BARS; i++) begin
         bm = bar_mask(i);
         a  = bar_ff[i] & bm & (bar_mem_ff[i] ? 32'hffff_fff0 : 32'hffff_fffc);
         mp = (bar_mem_ff[i] ? cmd_lo_ff[1] : cmd_lo_ff[0]) && a != 32'h0 && a != bm;
         if (state_ff == ST_BARS && bar_en_ff[i] &&
             (mp != mapped_ff[i] || (mp && a != base_ff[i]))) begin
            chg[i] = 1'b1;
            if (out_free) begin
               mapped_in[i] = mp;
               base_in[i]   = mp ? a : 32'h0;
            end
         end
      end

      // Load the result register
      if (state_ff == ST_EXEC && out_free && !(cmd_ff == CMD_WRITE && in_rng)) begin
         if (cmd_ff == CMD_IRQ && lvl_ff != irq_ff) begin
            irq_in = lvl_ff;
            irqn   = 1'b1;
         end
         rsp_valid_in = 1'b1;
         rsp_data_in  = '0;
         case (cmd_ff)
            CMD_READ: begin
               rsp_data_in[31:0] = in_rng ? rdata : 32'hffff_ffff;
               rsp_data_in[32]   = !in_rng;
            end
            CMD_WRITE: rsp_data_in[32] = 1'b1;
            CMD_DECODE: begin
               rsp_data_in[33]    = hit;
               rsp_data_in[36:34] = bidx;
               rsp_data_in[68:37] = boff;
            end
            default: rsp_data_in[75] = irqn;
         endcase
         rsp_data_in[76] = cmd_b10_ff;
      end else if (state_ff == ST_BARS && out_free) begin
         rsp_valid_in       = 1'b1;
         rsp_data_in        = '0;
         rsp_data_in[74:69] = chg;
         rsp_data_in[76]    = cmd_b10_ff;
      end

      // A change of BAR presence drops that BAR's mapping
      if (csr_we && csr_index == CSR_BAR_EN) begin
         for (int i = 0; i < NUM_BARS; i++) begin
            if (csr_wdata[i] != bar_en_ff[i]) begin
               mapped_in[i] = 1'b0;
               base_in[i]   = 32'h0;
            end
         end
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         irq_ff       <= 1'b0;
         cmd_lo_ff    <= '0;
         cmd_b10_ff   <= 1'b0;
         cls_ff       <= '0;
         intl_ff      <= '0;
         id_ff        <= '0;
         class_ff     <= '0;
         subsys_ff    <= '0;
         misc_ff      <= '0;
         bar_en_ff    <= '0;
         bar_mem_ff   <= '0;
         bar_sz_ff    <= '0;
         bar_typ_ff   <= '0;
         for (int i = 0; i < NUM_BARS; i++) begin
            bar_ff[i]    <= '0;
            base_ff[i]   <= '0;
            mapped_ff[i] <= 1'b0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         irq_ff       <= irq_in;
         cmd_lo_ff    <= cmd_lo_in;
         cmd_b10_ff   <= cmd_b10_in;
         cls_ff       <= cls_in;
         intl_ff      <= intl_in;
         for (int i = 0; i < NUM_BARS; i++) begin
            bar_ff[i]    <= bar_in[i];
            base_ff[i]   <= base_in[i];
            mapped_ff[i] <= mapped_in[i];
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_ID:      id_ff      <= csr_wdata[31:0];
               CSR_CLASS:   class_ff   <= csr_wdata[23:0];
               CSR_SUBSYS:  subsys_ff  <= csr_wdata[31:0];
               CSR_MISC:    misc_ff    <= csr_wdata[18:0];
               CSR_BAR_EN:  bar_en_ff  <= csr_wdata[5:0];
               CSR_BAR_MEM: bar_mem_ff <= csr_wdata[5:0];
               CSR_BAR_SZ:  bar_sz_ff  <= csr_wdata[35:0];
               CSR_BAR_TYP: bar_typ_ff <= csr_wdata[17:0];
               default: ;
            endcase
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         cmd_ff   <= req_tuser;
         addr_ff  <= req_tdata[31:0];
         wdata_ff <= req_tdata[63:32];
         nb_ff    <= req_tdata[66:64];
         space_ff <= req_tdata[67];
         lvl_ff   <= req_tdata[68];
      end
   end

endmodule
`default_nettype wire
